// ----- design/v2dc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2dc_pkg
// Shared constants and types for the valid-mode 2D convolution core.
// ----------------------------------------------------------------------------
package v2dc_pkg;

  localparam int KMAX       = 5;
  localparam int KTAPS      = KMAX * KMAX;
  localparam int LROWS      = KMAX - 1;
  localparam int WMAX       = 1024;
  localparam int HMAX       = 1024;
  localparam int PIX_W      = 16;
  localparam int COEF_W     = 16;
  localparam int POS_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int KSZ_W      = 3;
  localparam int KIDX_W     = 5;
  localparam int PROD_W     = PIX_W + COEF_W;
  localparam int SUM_W      = 37;
  localparam int LINE_W     = LROWS * PIX_W;
  localparam int COL_ADDR_W = $clog2(WMAX);

  localparam logic [1:0] REG_IMG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERN_ROWS  = 2'd2;
  localparam logic [1:0] REG_KERN_COLS  = 2'd3;

  localparam logic REQ_COEF  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef logic signed [PIX_W-1:0]  pix_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic              is_pix;
    logic [KIDX_W-1:0] cidx;
    coef_t             cval;
    pix_t              pix;
    logic [POS_W-1:0]  col;
    logic              emit;
    logic [POS_W-1:0]  orow;
    logic [POS_W-1:0]  ocol;
    logic              last;
  } item_t;

endpackage

// ----- design/valid_2d_convolution_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valid_2d_convolution_core
// Valid-mode 2D cross-correlation over a pixel stream with a loadable kernel.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless out_tready stalls the output; five
// registered stages with a per-stage valid, the line store read registered
// into s1, ahead of the window update in the stage after it.
// Reset: synchronous active-low rst_n clears valids, position and kernel and
// loads the default sizes; line store and window hold undefined data until
// written.
// ----------------------------------------------------------------------------
module valid_2d_convolution_core
  import v2dc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // coef_index[4:0], coef_value[20:5], pixel_value[36:21]
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_value[36:0], out_row[46:37], out_col[56:47]
  output logic        out_tlast   // last_of_frame
);

  logic [SIZE_W-1:0] img_w_r, img_h_r;
  logic [KSZ_W-1:0]  kr_cfg_r, kc_cfg_r;
  logic [SIZE_W-1:0] w_c, h_c;
  logic [KSZ_W-1:0]  kr_c, kc_c;

  logic [POS_W-1:0]  prow_r, pcol_r, prow_nxt, pcol_nxt;
  logic [POS_W-1:0]  row_q, col_q;

  item_t s0_r, s0_nxt, s1_r;
  logic  v0_r, v1_r, v2_r, v3_r, v4_r;
  logic  en0, en1, en2, en3, en4;

  logic [LINE_W-1:0] line_mem [WMAX];
  logic [LINE_W-1:0] rd_r, fwd_data_r, line_q, line_wdata;
  logic              fwd_r, line_we;

  pix_t  win_r [KMAX][KMAX];
  pix_t  win_nxt [KMAX][KMAX];
  pix_t  colv [KMAX];
  coef_t kern_r [KTAPS];
  coef_t ksel [KMAX][KMAX];
  logic  kmask [KMAX][KMAX];
  prod_t prod_r [KTAPS];
  sum_t  psum_r [KMAX];
  sum_t  psum_nxt [KMAX];
  sum_t  total_nxt, out_val_r;

  logic [POS_W-1:0] orow2_r, ocol2_r, orow3_r, ocol3_r, orow4_r, ocol4_r;
  logic             last2_r, last3_r, last4_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= SIZE_W'(28);
      img_h_r  <= SIZE_W'(28);
      kr_cfg_r <= KSZ_W'(5);
      kc_cfg_r <= KSZ_W'(5);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMG_WIDTH:  img_w_r  <= cfg_data;
        REG_IMG_HEIGHT: img_h_r  <= cfg_data;
        REG_KERN_ROWS:  kr_cfg_r <= cfg_data[KSZ_W-1:0];
        REG_KERN_COLS:  kc_cfg_r <= cfg_data[KSZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c  = (img_w_r == '0) ? SIZE_W'(1) : ((img_w_r > SIZE_W'(WMAX)) ? SIZE_W'(WMAX) : img_w_r);
    h_c  = (img_h_r == '0) ? SIZE_W'(1) : ((img_h_r > SIZE_W'(HMAX)) ? SIZE_W'(HMAX) : img_h_r);
    kr_c = (kr_cfg_r == '0) ? KSZ_W'(1) :
           ((kr_cfg_r > KSZ_W'(KMAX)) ? KSZ_W'(KMAX) : kr_cfg_r);
    kc_c = (kc_cfg_r == '0) ? KSZ_W'(1) :
           ((kc_cfg_r > KSZ_W'(KMAX)) ? KSZ_W'(KMAX) : kc_cfg_r);
  end

  // stage enables: a stage advances when empty or when the next one advances
  assign en4 = !v4_r || out_tready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;
  assign in_tready = en0;

  // position bookkeeping at acceptance
  always_comb begin
    logic wrap;
    wrap  = ({1'b0, pcol_r} >= w_c) || ({1'b0, prow_r} >= h_c);
    row_q = wrap ? '0 : prow_r;
    col_q = wrap ? '0 : pcol_r;
    s0_nxt.is_pix = in_tuser;
    s0_nxt.cidx   = in_tdata[4:0];
    s0_nxt.cval   = in_tdata[20:5];
    s0_nxt.pix    = in_tdata[36:21];
    s0_nxt.col    = col_q;
    s0_nxt.emit   = ({1'b0, row_q} + SIZE_W'(1) >= SIZE_W'(kr_c)) &&
                    ({1'b0, col_q} + SIZE_W'(1) >= SIZE_W'(kc_c));
    s0_nxt.orow   = row_q + POS_W'(1) - POS_W'(kr_c);
    s0_nxt.ocol   = col_q + POS_W'(1) - POS_W'(kc_c);
    s0_nxt.last   = ({1'b0, row_q} == h_c - SIZE_W'(1)) &&
                    ({1'b0, col_q} == w_c - SIZE_W'(1));
    prow_nxt = prow_r;
    pcol_nxt = pcol_r;
    if (in_tuser == REQ_PIXEL) begin
      if ({1'b0, col_q} + SIZE_W'(1) >= w_c) begin
        pcol_nxt = '0;
        prow_nxt = ({1'b0, row_q} + SIZE_W'(1) >= h_c) ? '0 : row_q + POS_W'(1);
      end else begin
        pcol_nxt = col_q + POS_W'(1);
        prow_nxt = row_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prow_r <= '0;
      pcol_r <= '0;
      v0_r   <= 1'b0;
    end else if (en0) begin
      v0_r <= in_tvalid;
      if (in_tvalid) begin
        prow_r <= prow_nxt;
        pcol_r <= pcol_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_tvalid) s0_r <= s0_nxt;
  end

  // line store: one word per column holds the last rows, newest in the low lane
  assign line_we    = en2 && v1_r && s1_r.is_pix;
  assign line_wdata = {line_q[LINE_W-PIX_W-1:0], s1_r.pix};

  always_ff @(posedge clk) begin
    if (line_we) line_mem[s1_r.col[COL_ADDR_W-1:0]] <= line_wdata;
    if (en1) begin
      rd_r       <= line_mem[s0_r.col[COL_ADDR_W-1:0]];
      fwd_r      <= line_we && (s1_r.col == s0_r.col);
      fwd_data_r <= line_wdata;
      s1_r       <= s0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en1) v1_r <= v0_r;
  end

  assign line_q = fwd_r ? fwd_data_r : rd_r;

  // new column and shifted window
  always_comb begin
    colv[KMAX-1] = s1_r.pix;
    for (int r = 0; r < LROWS; r++) colv[LROWS-1-r] = line_q[r*PIX_W +: PIX_W];
    for (int r = 0; r < KMAX; r++) begin
      for (int c = 0; c < KMAX - 1; c++) win_nxt[r][c] = win_r[r][c+1];
      win_nxt[r][KMAX-1] = colv[r];
    end
  end

  // coefficient for each window tap under the current kernel size
  always_comb begin
    logic [KSZ_W-1:0]  kr_i, kc_j;
    logic [KIDX_W-1:0] kidx;
    for (int i = 0; i < KMAX; i++) begin
      for (int j = 0; j < KMAX; j++) begin
        kr_i = KSZ_W'(i) + kr_c - KSZ_W'(KMAX);
        kc_j = KSZ_W'(j) + kc_c - KSZ_W'(KMAX);
        kidx = KIDX_W'(kr_i) * KIDX_W'(kc_c) + KIDX_W'(kc_j);
        kmask[i][j] = (4'(i) + {1'b0, kr_c} >= 4'(KMAX)) &&
                      (4'(j) + {1'b0, kc_c} >= 4'(KMAX));
        if (kmask[i][j])
          ksel[i][j] = kern_r[kidx];
        else
          ksel[i][j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KTAPS; k++) kern_r[k] <= '0;
    end else if (en2 && v1_r && !s1_r.is_pix && s1_r.cidx < KIDX_W'(KTAPS)) begin
      kern_r[s1_r.cidx] <= s1_r.cval;
    end
  end

  // drop taps outside the kernel so stale window data never reaches the sum
  always_ff @(posedge clk) begin
    if (en2 && v1_r && s1_r.is_pix) begin
      for (int r = 0; r < KMAX; r++)
        for (int c = 0; c < KMAX; c++) begin
          win_r[r][c]       <= win_nxt[r][c];
          prod_r[r*KMAX+c]  <= kmask[r][c] ? win_nxt[r][c] * ksel[r][c] : prod_t'(0);
        end
      orow2_r <= s1_r.orow;
      ocol2_r <= s1_r.ocol;
      last2_r <= s1_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en2) v2_r <= v1_r && s1_r.is_pix && s1_r.emit;
  end

  // row partial sums, then total
  always_comb begin
    for (int r = 0; r < KMAX; r++) begin
      psum_nxt[r] = '0;
      for (int c = 0; c < KMAX; c++) psum_nxt[r] = psum_nxt[r] + SUM_W'(prod_r[r*KMAX+c]);
    end
    total_nxt = '0;
    for (int r = 0; r < KMAX; r++) total_nxt = total_nxt + psum_r[r];
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      for (int r = 0; r < KMAX; r++) psum_r[r] <= psum_nxt[r];
      orow3_r <= orow2_r;
      ocol3_r <= ocol2_r;
      last3_r <= last2_r;
    end
    if (en4 && v3_r) begin
      out_val_r <= total_nxt;
      orow4_r   <= orow3_r;
      ocol4_r   <= ocol3_r;
      last4_r   <= last3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {7'd0, ocol4_r, orow4_r, out_val_r};
  assign out_tlast  = last4_r;

endmodule

// ----- tb/valid_2d_convolution_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valid_2d_convolution_core_tb
// Drives kernel loads, size settings and raster pixel frames into the core,
// predicts every window sum, row, column and frame-end flag, and checks each
// result word in order while both stream sides stall at random.
// ----------------------------------------------------------------------------
module valid_2d_convolution_core_tb;
  import v2dc_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] value;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } conv_res_t;

  typedef enum logic [1:0] {OP_CFG, OP_COEF, OP_PIX} op_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_TYPED, CHK_NONE} chk_e;

  typedef struct {
    op_e         op;
    int          idx;
    int          val;
    chk_e        chk;
    conv_res_t   res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // coef_index[4:0], coef_value[20:5], pixel_value[36:21]
  logic        in_tuser = 1'b0; // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // out_value[36:0], out_row[46:37], out_col[56:47]
  logic        out_tlast;       // last_of_frame

  valid_2d_convolution_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  coef_t            kern_q[KTAPS];
  pix_t             line_q[LROWS*WMAX];
  pix_t             win_q[KTAPS];
  int               pos_row, pos_col;
  logic [10:0]      size_w, size_h;
  logic [2:0]       size_kr, size_kc;

  conv_res_t        pending_q[$];
  int               err_cnt, words_sent, res_seen, frames_run;
  bit               quiet;

  function automatic int clamp_sz(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic bit conv_pixel(pix_t px, output conv_res_t res);
    int w, h, kr, kc, base;
    pix_t colv[KMAX];
    logic signed [63:0] acc;
    bit emit;
    w  = clamp_sz(size_w, WMAX);
    h  = clamp_sz(size_h, HMAX);
    kr = clamp_sz(size_kr, KMAX);
    kc = clamp_sz(size_kc, KMAX);
    if (pos_col >= w || pos_row >= h) begin
      pos_col = 0;
      pos_row = 0;
    end
    base = pos_col * LROWS;
    colv[KMAX-1] = px;
    for (int r = 0; r < LROWS; r++) colv[LROWS-1-r] = line_q[base+r];
    for (int r = LROWS; r > 1; r--) line_q[base+r-1] = line_q[base+r-2];
    line_q[base] = px;
    for (int r = 0; r < KMAX; r++) begin
      for (int c = 0; c < KMAX-1; c++) win_q[r*KMAX+c] = win_q[r*KMAX+c+1];
      win_q[r*KMAX+KMAX-1] = colv[r];
    end
    emit = (pos_row + 1 >= kr) && (pos_col + 1 >= kc);
    res = '0;
    if (emit) begin
      acc = 0;
      for (int r = 0; r < kr; r++)
        for (int c = 0; c < kc; c++)
          acc += 64'(win_q[(KMAX-kr+r)*KMAX + (KMAX-kc+c)]) * 64'(kern_q[r*kc+c]);
      if (acc > 64'sd68719476735) acc = 64'sd68719476735;
      if (acc < -64'sd68719476736) acc = -64'sd68719476736;
      res.value = acc[SUM_W-1:0];
      res.row   = POS_W'(pos_row + 1 - kr);
      res.col   = POS_W'(pos_col + 1 - kc);
      res.last  = (pos_row == h-1) && (pos_col == w-1);
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
    return emit;
  endfunction

  task automatic send_word(logic kind, logic [4:0] cidx, logic [15:0] cval,
                           logic [15:0] pix, chk_e chk, conv_res_t typed);
    conv_res_t res;
    bit emit;
    while (!quiet && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, pix, cval, cidx};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (kind == REQ_COEF) begin
      if (cidx < KTAPS) kern_q[cidx] = cval;
    end else begin
      emit = conv_pixel(pix, res);
      if (chk == CHK_TYPED) pending_q.push_back(typed);
      else if (chk == CHK_MODEL && emit) pending_q.push_back(res);
      else if (chk == CHK_NONE && emit) begin
        $error("directed row predicts a result where none is due");
        err_cnt++;
      end
    end
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    in_tvalid <= 1'b0;
    @(negedge clk);
    wait (pending_q.size() == 0);
    repeat (12) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IMG_WIDTH:  size_w  = val;
      REG_IMG_HEIGHT: size_h  = val;
      REG_KERN_ROWS:  size_kr = val[2:0];
      default:        size_kc = val[2:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_sizes(int w, int h, int kr, int kc);
    write_reg(REG_IMG_WIDTH, 11'(w));
    write_reg(REG_IMG_HEIGHT, 11'(h));
    write_reg(REG_KERN_ROWS, 11'(kr));
    write_reg(REG_KERN_COLS, 11'(kc));
  endtask

  task automatic send_pix(logic [15:0] px);
    send_word(REQ_PIXEL, 5'($urandom), 16'($urandom), px, CHK_MODEL, '0);
  endtask

  task automatic send_coef(logic [4:0] idx, logic [15:0] v);
    send_word(REQ_COEF, idx, v, 16'($urandom), CHK_MODEL, '0);
  endtask

  function automatic logic [15:0] rand_pix();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(negedge clk)
    out_tready <= quiet || ($urandom_range(0, 99) >= 7);

  always @(posedge clk) begin
    conv_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      res_seen++;
      if (pending_q.size() == 0) begin
        $error("result word with none expected: %h", out_tdata);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (out_tdata[36:0] !== want.value) begin
          $error("out_value: expected %0d, got %0d", $signed(want.value),
                 $signed(out_tdata[36:0]));
          err_cnt++;
        end
        if (out_tdata[46:37] !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_tdata[46:37]);
          err_cnt++;
        end
        if (out_tdata[56:47] !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_tdata[56:47]);
          err_cnt++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_frame: expected %0b, got %0b", want.last, out_tlast);
          err_cnt++;
        end
      end
    end
  end

  stim_row_t dir_tab[] = '{
    '{OP_CFG,  REG_IMG_WIDTH,  2,      CHK_MODEL, '0},
    '{OP_CFG,  REG_IMG_HEIGHT, 2,      CHK_MODEL, '0},
    '{OP_CFG,  REG_KERN_ROWS,  1,      CHK_MODEL, '0},
    '{OP_CFG,  REG_KERN_COLS,  1,      CHK_MODEL, '0},
    '{OP_COEF, 0,              'h4000, CHK_MODEL, '0},
    '{OP_COEF, 31,             'h7FFF, CHK_MODEL, '0},
    '{OP_PIX,  0, 'h7FFF, CHK_TYPED, '{37'sd536854528,  10'd0, 10'd0, 1'b0}},
    '{OP_PIX,  0, 'h8000, CHK_TYPED, '{-37'sd536870912, 10'd0, 10'd1, 1'b0}},
    '{OP_PIX,  0, 'h0001, CHK_TYPED, '{37'sd16384,      10'd1, 10'd0, 1'b0}},
    '{OP_PIX,  0, 'hFFFF, CHK_TYPED, '{-37'sd16384,     10'd1, 10'd1, 1'b1}},
    '{OP_CFG,  REG_KERN_ROWS,  7,      CHK_MODEL, '0},
    '{OP_CFG,  REG_KERN_COLS,  0,      CHK_MODEL, '0},
    '{OP_PIX,  0, 'h1234, CHK_NONE,  '0},
    '{OP_PIX,  0, 'h5678, CHK_NONE,  '0},
    '{OP_PIX,  0, 'h0F0F, CHK_NONE,  '0},
    '{OP_PIX,  0, 'hF0F0, CHK_NONE,  '0},
    '{OP_CFG,  REG_IMG_WIDTH,  3,      CHK_MODEL, '0},
    '{OP_CFG,  REG_IMG_HEIGHT, 3,      CHK_MODEL, '0},
    '{OP_CFG,  REG_KERN_ROWS,  2,      CHK_MODEL, '0},
    '{OP_CFG,  REG_KERN_COLS,  2,      CHK_MODEL, '0},
    '{OP_COEF, 24,             'h8000, CHK_MODEL, '0},
    '{OP_COEF, 3,              'h7FFF, CHK_MODEL, '0},
    '{OP_PIX,  0, 'h0100, CHK_MODEL, '0},
    '{OP_PIX,  0, 'h7FFF, CHK_MODEL, '0},
    '{OP_PIX,  0, 'h8000, CHK_MODEL, '0},
    '{OP_PIX,  0, 'h0200, CHK_MODEL, '0},
    '{OP_PIX,  0, 'h7FFF, CHK_MODEL, '0},
    '{OP_PIX,  0, 'h8000, CHK_MODEL, '0},
    '{OP_CFG,  REG_IMG_HEIGHT, 1,      CHK_MODEL, '0}
  };

  initial begin
    int w, h, kr, kc;
    for (int i = 0; i < KTAPS; i++) begin
      kern_q[i] = '0;
      win_q[i]  = '0;
    end
    foreach (line_q[i]) line_q[i] = '0;
    pos_row = 0;
    pos_col = 0;
    size_w  = 11'd28;
    size_h  = 11'd28;
    size_kr = 3'd5;
    size_kc = 3'd5;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      case (dir_tab[i].op)
        OP_CFG:  write_reg(2'(dir_tab[i].idx), 11'(dir_tab[i].val));
        OP_COEF: send_word(REQ_COEF, 5'(dir_tab[i].idx), 16'(dir_tab[i].val), 16'h0,
                           CHK_MODEL, '0);
        default: send_word(REQ_PIXEL, 5'h0, 16'h0, 16'(dir_tab[i].val),
                           dir_tab[i].chk, dir_tab[i].res);
      endcase
    end
    // restart after height shrank below the current row
    for (int i = 0; i < 3; i++) send_pix(rand_pix());

    // widest frame and the first rows of the tallest, sizes above their maximum
    for (int i = 0; i < KTAPS; i++) send_coef(5'(i), 16'($urandom));
    set_sizes(2047, 1, 1, 5);
    for (int i = 0; i < WMAX; i++) send_pix(rand_pix());
    set_sizes(1, 1500, 6, 1);
    for (int i = 0; i < 120; i++) send_pix(rand_pix());
    frames_run = 2;

    while (words_sent < 1850) begin
      quiet = (words_sent > 1400 && words_sent < 1650);
      w  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      h  = $urandom_range(0, 12);
      kr = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 5);
      kc = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 5);
      set_sizes(w, h, kr, kc);
      for (int i = 0; i < clamp_sz(kr, KMAX) * clamp_sz(kc, KMAX); i++)
        send_coef(5'(i), 16'($urandom));
      repeat ($urandom_range(0, 2)) send_coef(5'($urandom), 16'($urandom));
      for (int i = 0; i < clamp_sz(w, WMAX) * clamp_sz(h, HMAX); i++) begin
        if ($urandom_range(0, 49) == 0) send_coef(5'($urandom), 16'($urandom));
        send_pix(rand_pix());
      end
      frames_run++;
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (20) @(posedge clk);
    $display("sent %0d words over %0d frames, checked %0d result words",
             words_sent, frames_run, res_seen);
    if (err_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pending_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
design/v2dc_pkg.sv
design/valid_2d_convolution_core.sv
tb/valid_2d_convolution_core_tb.sv
